// ----- rtl/arp_cache_responder_unit_defines.svh -----
// ----------------------------------------------------------------------------
// ARP cache responder assertion macros
// Shared property wrappers for the concurrent checks of the ARP cache.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_RESPONDER_UNIT_DEFINES_SVH
`define ARP_CACHE_RESPONDER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arpc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ARPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arpc: next-cycle check failed");

`endif

// ----- rtl/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// ARP cache package
// Types, codes and constants shared by the ARP cache modules.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

  localparam logic [31:0] MY_IP_RESET  = 32'h0A00_0004;
  localparam logic [47:0] MY_MAC_RESET = 48'h0;
  localparam logic [7:0]  BCAST_BYTE   = 8'hFF;
  localparam logic [47:0] BCAST_MAC    = {6{BCAST_BYTE}};

  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;
  localparam logic [15:0] OP_REPLY    = 16'h0002;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_MY_IP  = 1'b0;
  localparam logic CFG_MY_MAC = 1'b1;

  typedef enum logic [1:0] {
    ENT_FREE     = 2'd0,
    ENT_WAITING  = 2'd1,
    ENT_RESOLVED = 2'd2
  } ent_state_t;

  typedef enum logic [3:0] {
    STAT_LEARNED   = 4'd0,
    STAT_BAD_HW    = 4'd1,
    STAT_BAD_PROTO = 4'd2,
    STAT_NOT_OURS  = 4'd3,
    STAT_FULL      = 4'd4,
    STAT_BAD_OP    = 4'd5,
    STAT_HIT       = 4'd6,
    STAT_PENDING   = 4'd7,
    STAT_REQUESTED = 4'd8
  } arpc_status_t;

  typedef enum logic [1:0] {
    SEND_NONE    = 2'd0,
    SEND_REPLY   = 2'd1,
    SEND_REQUEST = 2'd2
  } send_kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } ctrl_state_t;

  // One table entry as it is stored in the memory.
  typedef struct packed {
    ent_state_t  st;
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  // Summary of one pass over the table.
  typedef struct packed {
    logic        done;
    logic        hit;
    logic        hit_resolved;
    logic        free_found;
    logic [47:0] hit_mac;
  } scan_res_t;

endpackage

`default_nettype wire

// ----- rtl/arp_cache_responder_unit.sv -----
// ----------------------------------------------------------------------------
// ARP cache responder
// Keeps an ARP table in a single memory and answers incoming ARP packets
// and address lookups with one result each.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result has been produced, and one result follows each item.
// The scan reads the table memory through its single read port one entry
// per cycle, then decides and writes back at most once.
// The result appears for exactly one cycle with out_valid high and cannot be
// stalled, so the receiver must take it in that cycle. Entries come out of
// reset free through per-entry valid flags, so no clearing pass is needed;
// configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

`include "arp_cache_responder_unit_defines.svh"

module arp_cache_responder_unit
  import arpc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [47:0] cfg_wdata,
  // items
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_kind,
  input  wire logic [15:0] in_hw_type,
  input  wire logic [15:0] in_proto_type,
  input  wire logic [15:0] in_opcode,
  input  wire logic [31:0] in_sender_ip,
  input  wire logic [47:0] in_sender_mac,
  input  wire logic [31:0] in_target_ip,
  input  wire logic [31:0] in_lookup_ip,
  // results
  output logic             out_valid,
  output logic      [3:0]  out_status,
  output logic      [47:0] out_mac_out,
  output logic      [1:0]  out_send_packet,
  output logic      [47:0] out_dest_mac,
  output logic      [31:0] out_dest_ip
);

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned ENT_W = $bits(entry_t);

  ctrl_state_t state_r, state_nxt;
  logic [31:0] my_ip_r;
  logic [47:0] my_mac_r;
  logic [CACHE_ENTRIES-1:0] valid_r, valid_nxt;

  logic        kind_r;
  logic [15:0] hw_r, proto_r, op_r;
  logic [31:0] sip_r, tip_r, lip_r;
  logic [47:0] smac_r;

  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_status_r;
  logic [47:0] out_mac_r, out_dmac_r;
  logic [1:0]  out_send_r;
  logic [31:0] out_dip_r;

  arpc_status_t status_nxt;
  send_kind_t   send_nxt;
  logic [47:0]  mac_nxt, dmac_nxt;
  logic [31:0]  dip_nxt;

  logic             accept;
  logic             finish;
  logic [31:0]      key;
  scan_res_t        scan_res;
  logic [IDX_W-1:0] hit_idx, free_idx;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] ram_rdata;
  entry_t           rd_entry;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           wr_entry;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign finish = (state_r == ST_SCAN) && scan_res.done;
  assign key    = (kind_r == KIND_LOOKUP) ? lip_r : sip_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_ip_r  <= MY_IP_RESET;
      my_mac_r <= MY_MAC_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MY_IP:  my_ip_r  <= cfg_wdata[31:0];
        CFG_MY_MAC: my_mac_r <= cfg_wdata;
        default:    my_ip_r  <= my_ip_r;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      hw_r    <= in_hw_type;
      proto_r <= in_proto_type;
      op_r    <= in_opcode;
      sip_r   <= in_sender_ip;
      smac_r  <= in_sender_mac;
      tip_r   <= in_target_ip;
      lip_r   <= in_lookup_ip;
    end
  end

  arpc_scan #(
    .ENTRIES(CACHE_ENTRIES)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (accept),
    .key      (key),
    .ent_valid(valid_r),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .res      (scan_res),
    .hit_idx  (hit_idx),
    .free_idx (free_idx)
  );

  arpc_ram #(
    .WIDTH(ENT_W),
    .DEPTH(CACHE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Decision after the scan: result fields and the single write-back.
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    status_nxt    = STAT_LEARNED;
    send_nxt      = SEND_NONE;
    mac_nxt       = '0;
    dmac_nxt      = '0;
    dip_nxt       = '0;
    ram_we        = 1'b0;
    ram_waddr     = scan_res.hit ? hit_idx : free_idx;
    wr_entry.st   = ENT_RESOLVED;
    wr_entry.ip   = sip_r;
    wr_entry.mac  = smac_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (kind_r == KIND_PACKET) begin
            if (hw_r != HW_ETHERNET) begin
              status_nxt = STAT_BAD_HW;
            end else if (proto_r != PROTO_IPV4) begin
              status_nxt = STAT_BAD_PROTO;
            end else begin
              // A known sender is refreshed even when the packet is not ours.
              ram_we = scan_res.hit;
              if (tip_r != my_ip_r) begin
                status_nxt = STAT_NOT_OURS;
              end else if (!scan_res.hit && !scan_res.free_found) begin
                status_nxt = STAT_FULL;
              end else begin
                ram_we = 1'b1;
                if (op_r == OP_REQUEST) begin
                  status_nxt = STAT_LEARNED;
                  send_nxt   = SEND_REPLY;
                  dmac_nxt   = smac_r;
                  dip_nxt    = sip_r;
                end else if (op_r == OP_REPLY) begin
                  status_nxt = STAT_LEARNED;
                end else begin
                  status_nxt = STAT_BAD_OP;
                end
              end
            end
          end else begin
            if (scan_res.hit) begin
              if (scan_res.hit_resolved) begin
                status_nxt = STAT_HIT;
                mac_nxt    = scan_res.hit_mac;
              end else begin
                status_nxt = STAT_PENDING;
              end
            end else if (scan_res.free_found) begin
              ram_we       = 1'b1;
              wr_entry.st  = ENT_WAITING;
              wr_entry.ip  = lip_r;
              wr_entry.mac = '0;
              status_nxt   = STAT_REQUESTED;
              send_nxt     = SEND_REQUEST;
              dmac_nxt     = BCAST_MAC;
              dip_nxt      = lip_r;
            end else begin
              status_nxt = STAT_FULL;
            end
          end
          if (ram_we) begin
            valid_nxt[ram_waddr] = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status_r <= status_nxt;
      out_mac_r    <= mac_nxt;
      out_send_r   <= send_nxt;
      out_dmac_r   <= dmac_nxt;
      out_dip_r    <= dip_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_mac_out     = out_mac_r;
  assign out_send_packet = out_send_r;
  assign out_dest_mac    = out_dmac_r;
  assign out_dest_ip     = out_dip_r;

  `ARPC_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  `ARPC_ASSERT_IMPL(a_done_in_scan, clk, rst_n, scan_res.done, state_r == ST_SCAN)
  `ARPC_ASSERT_NEXT(a_write_then_result, clk, rst_n, ram_we, out_valid)
  `ARPC_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  `ARPC_ASSERT_IMPL(a_reply_learned, clk, rst_n, out_valid && (out_send_packet == SEND_REPLY), out_status == STAT_LEARNED)

endmodule

`default_nettype wire

// ----- rtl/arpc_ram.sv -----
// ----------------------------------------------------------------------------
// ARP cache RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/arpc_scan.sv -----
// ----------------------------------------------------------------------------
// ARP cache table scanner
// Walks the table memory one entry per cycle and records the first entry
// that holds the key and the first free entry.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_scan
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic [31:0]        key,
  input  wire logic [ENTRIES-1:0] ent_valid,
  output logic                    rd_en,
  output logic      [IDX_W-1:0]   rd_addr,
  input  wire entry_t             rd_entry,
  output scan_res_t               res,
  output logic      [IDX_W-1:0]   hit_idx,
  output logic      [IDX_W-1:0]   free_idx
);

  logic             run_r, run_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             chk_vld_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             done_r, done_nxt;
  logic             hit_r, hit_nxt;
  logic             hit_res_r, hit_res_nxt;
  logic [47:0]      hit_mac_r, hit_mac_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             cur_valid;

  // Read addresses are issued one per cycle; the data for an address comes
  // back in the next cycle, tagged by chk_idx_r.
  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (run_r) begin
      cnt_nxt = cnt_r + IDX_W'(1);
      if (cnt_r == IDX_W'(ENTRIES - 1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  assign rd_en   = run_r;
  assign rd_addr = cnt_r;

  assign cur_valid = ent_valid[chk_idx_r];

  always_comb begin
    hit_nxt      = hit_r;
    hit_res_nxt  = hit_res_r;
    hit_mac_nxt  = hit_mac_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    if (go) begin
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
    end else if (chk_vld_r) begin
      if (cur_valid && (rd_entry.ip == key) && !hit_r) begin
        hit_nxt     = 1'b1;
        hit_res_nxt = (rd_entry.st == ENT_RESOLVED);
        hit_mac_nxt = rd_entry.mac;
        hit_idx_nxt = chk_idx_r;
      end
      if (!cur_valid && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = chk_idx_r;
      end
    end
    done_nxt = chk_vld_r && (chk_idx_r == IDX_W'(ENTRIES - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      chk_vld_r <= 1'b0;
      done_r    <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
    end else begin
      run_r     <= run_nxt;
      chk_vld_r <= run_r;
      done_r    <= done_nxt;
      hit_r     <= hit_nxt;
      free_r    <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    chk_idx_r  <= cnt_r;
    hit_res_r  <= hit_res_nxt;
    hit_mac_r  <= hit_mac_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  assign res.done         = done_r;
  assign res.hit          = hit_r;
  assign res.hit_resolved = hit_res_r;
  assign res.free_found   = free_r;
  assign res.hit_mac      = hit_mac_r;
  assign hit_idx          = hit_idx_r;
  assign free_idx         = free_idx_r;

endmodule

`default_nettype wire
